// File: hdl/sert_pkg.sv
// Shared types and codes for the speculative epoch ring tracker.
`default_nettype none
package sert_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned SlotBits = $clog2(Depth);

  localparam int unsigned ReqBits  = 4;
  localparam int unsigned CodeBits = 2;
  localparam int unsigned StBits   = 3;

  localparam logic [ReqBits-1:0] ReqNext     = 4'd0;
  localparam logic [ReqBits-1:0] ReqSetDone  = 4'd1;
  localparam logic [ReqBits-1:0] ReqRollback = 4'd2;
  localparam logic [ReqBits-1:0] ReqRbDone   = 4'd3;
  localparam logic [ReqBits-1:0] ReqGetCmt   = 4'd4;
  localparam logic [ReqBits-1:0] ReqCmtDone  = 4'd5;
  localparam logic [ReqBits-1:0] ReqStop     = 4'd6;
  localparam logic [ReqBits-1:0] ReqStatus   = 4'd7;
  localparam logic [ReqBits-1:0] ReqSetTask  = 4'd8;
  localparam logic [ReqBits-1:0] ReqGetTask  = 4'd9;

  localparam logic [CodeBits-1:0] CodeOk      = 2'd0;
  localparam logic [CodeBits-1:0] CodeBusy    = 2'd1;
  localparam logic [CodeBits-1:0] CodeStopped = 2'd2;
  localparam logic [CodeBits-1:0] CodeIllegal = 2'd3;

  localparam logic [StBits-1:0] StCommit = 3'd0;
  localparam logic [StBits-1:0] StExec   = 3'd1;
  localparam logic [StBits-1:0] StDone   = 3'd2;
  localparam logic [StBits-1:0] StPend   = 3'd3;
  localparam logic [StBits-1:0] StRb     = 3'd4;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] epoch_in;
    logic [15:0] task_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       result_code;
    logic [31:0]      epoch_out;
    logic [2:0]       status_out;
    logic [15:0]      task_out;
    logic [31:0]      head_epoch;
    logic [31:0]      tail_epoch;
    logic [Depth-1:0] rollback_flags;
  } rsp_t;

endpackage
`default_nettype wire

// File: hdl/sert_front.sv
// Request intake: two-entry queue in front of the executor.
`default_nettype none
module sert_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire sert_pkg::req_t req_i,
  output logic               vld_o,
  input  wire logic          take_i,
  output sert_pkg::req_t     req_o
);
  sert_pkg::req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign full_o = cnt_q[1];
  assign vld_o  = cnt_q != 2'd0;
  assign req_o  = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = take_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// File: hdl/sert_back.sv
// Request executor: slot state, cursors and the rollback and commit walks.
`default_nettype none
module sert_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           vld_i,
  output logic                take_o,
  input  wire sert_pkg::req_t req_i,
  output logic                rvld_o,
  input  wire logic           rtake_i,
  output sert_pkg::rsp_t      rsp_o
);
  localparam int unsigned SB = sert_pkg::SlotBits;
  localparam int unsigned KB = $clog2(sert_pkg::Depth + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_RB = 3'b010, S_CMT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [2:0]  st_q [sert_pkg::Depth];
  logic [2:0]  st_d [sert_pkg::Depth];
  logic [15:0] tk_q [sert_pkg::Depth];
  logic [15:0] tk_d [sert_pkg::Depth];
  logic [31:0] first_q, first_d, next_q, next_d, cmt_q, cmt_d, stop_q, stop_d;
  logic [31:0] walk_q, walk_d, dist_q, dist_d;
  logic [sert_pkg::Depth-1:0] flag_q, flag_d;
  logic [KB-1:0] k_q, k_d;
  sert_pkg::rsp_t rsp_q, rsp_d;
  logic rvld_q, rvld_d;

  function automatic logic [SB-1:0] slot(input logic [31:0] e);
    return e[SB-1:0];
  endfunction
  function automatic logic sge(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31];
  endfunction
  function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31] && d != 32'd0;
  endfunction
  function automatic logic slt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  logic stop_set, out_free, go;
  logic [SB-1:0] s_in, s_nx, s_cm, s_fi, s_wk;
  logic [2:0] st_in;
  logic [31:0] rb_start, stop_nx, cm_first;
  assign stop_set = sge(stop_q, first_q);
  assign out_free = !rvld_q || rtake_i;
  assign go       = state_q == S_IDLE && vld_i && out_free;
  assign take_o   = go;
  assign s_in = slot(req_i.epoch_in);
  assign s_nx = slot(next_q);
  assign s_cm = slot(cmt_q);
  assign s_fi = slot(first_q);
  assign s_wk = slot(walk_q);
  assign st_in = st_q[s_in];
  assign rvld_o = rvld_q;
  assign rsp_o  = rsp_q;
  // the walk pointer has moved k slots on from the rollback start
  assign rb_start = walk_q - 32'(k_q);
  assign stop_nx  = req_i.epoch_in + 32'd1;
  assign cm_first = (k_q == KB'(sert_pkg::Depth)) ? cmt_q : first_q;

  // walk termination
  logic rb_end, cm_end;
  assign rb_end = k_q == KB'(sert_pkg::Depth) || {{(32-KB){1'b0}}, k_q} >= dist_q;
  assign cm_end = k_q == KB'(sert_pkg::Depth) || first_q == cmt_q ||
                  st_q[s_fi] != sert_pkg::StCommit;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    tk_d = tk_q;
    first_d = first_q; next_d = next_q; cmt_d = cmt_q; stop_d = stop_q;
    walk_d = walk_q; dist_d = dist_q; flag_d = flag_q; k_d = k_q;
    rsp_d = rsp_q;
    rvld_d = rvld_q;
    if (rtake_i && rvld_q) rvld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          rsp_d = '0;
          rvld_d = 1'b1;
          case (req_i.req_type)
            sert_pkg::ReqNext: begin
              if (next_q != first_q && s_nx == s_fi)
                rsp_d.result_code = sert_pkg::CodeBusy;
              else if (st_q[s_nx] == sert_pkg::StPend)
                rsp_d.result_code = sert_pkg::CodeBusy;
              else if (stop_set && sge(next_q, stop_q))
                rsp_d.result_code = (stop_q == first_q) ? sert_pkg::CodeStopped
                                                        : sert_pkg::CodeBusy;
              else if (st_q[s_nx] != sert_pkg::StCommit && st_q[s_nx] != sert_pkg::StRb)
                rsp_d.result_code = sert_pkg::CodeIllegal;
              else begin
                rsp_d.epoch_out  = next_q;
                rsp_d.status_out = st_q[s_nx];
                st_d[s_nx] = sert_pkg::StExec;
                next_d = next_q + 32'd1;
              end
            end
            sert_pkg::ReqSetDone: begin
              rsp_d.status_out = st_in;
              if (st_in == sert_pkg::StExec) st_d[s_in] = sert_pkg::StDone;
              else if (st_in == sert_pkg::StPend) st_d[s_in] = sert_pkg::StRb;
              else rsp_d.result_code = sert_pkg::CodeIllegal;
            end
            sert_pkg::ReqRollback: begin
              // hold the result until the walk ends
              rvld_d = 1'b0;
              state_d = S_RB;
              if (stop_set && sgt(stop_q, req_i.epoch_in)) stop_d = first_q - 32'd1;
              dist_d = slt(req_i.epoch_in, next_q) ? next_q - req_i.epoch_in : 32'd0;
              walk_d = req_i.epoch_in;
              k_d = '0;
            end
            sert_pkg::ReqRbDone: flag_d[s_in] = 1'b0;
            sert_pkg::ReqGetCmt: begin
              if (cmt_q == next_q || st_q[s_cm] != sert_pkg::StDone ||
                  (stop_set && stop_q == cmt_q))
                rsp_d.result_code = sert_pkg::CodeStopped;
              else begin
                rsp_d.epoch_out  = cmt_q;
                rsp_d.status_out = sert_pkg::StDone;
                rsp_d.task_out   = tk_q[s_cm];
                tk_d[s_cm] = '0;
                cmt_d = cmt_q + 32'd1;
              end
            end
            sert_pkg::ReqCmtDone: begin
              rsp_d.status_out = st_in;
              if (st_in != sert_pkg::StDone) rsp_d.result_code = sert_pkg::CodeIllegal;
              else begin
                rvld_d = 1'b0;
                state_d = S_CMT;
                st_d[s_in] = sert_pkg::StCommit;
                k_d = '0;
              end
            end
            sert_pkg::ReqStop: begin
              if (!(stop_set && slt(stop_q, stop_nx))) stop_d = stop_nx;
            end
            sert_pkg::ReqStatus:  rsp_d.status_out = st_in;
            sert_pkg::ReqSetTask: tk_d[s_in] = req_i.task_in;
            sert_pkg::ReqGetTask: rsp_d.task_out = tk_q[s_in];
            default: rsp_d.result_code = sert_pkg::CodeIllegal;
          endcase
          rsp_d.head_epoch     = first_d;
          rsp_d.tail_epoch     = next_d;
          rsp_d.rollback_flags = flag_d;
        end
      end
      S_RB: begin
        if (rb_end) begin
          // clamp next to the rollback start
          if (sgt(next_q, rb_start)) next_d = rb_start;
          rsp_d.tail_epoch     = next_d;
          rsp_d.rollback_flags = flag_q;
          rvld_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (st_q[s_wk] == sert_pkg::StExec) begin
            st_d[s_wk] = sert_pkg::StPend; flag_d[s_wk] = 1'b1;
          end else if (st_q[s_wk] == sert_pkg::StDone) begin
            st_d[s_wk] = sert_pkg::StRb; flag_d[s_wk] = 1'b1;
          end
          walk_d = walk_q + 32'd1;
          k_d = k_q + KB'(1);
        end
      end
      S_CMT: begin
        if (cm_end) begin
          first_d = cm_first;
          if (!sge(stop_q, cm_first)) stop_d = cm_first - 32'd1;
          rsp_d.head_epoch = cm_first;
          rvld_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          first_d = first_q + 32'd1;
          k_d = k_q + KB'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < sert_pkg::Depth; i++) begin
        st_q[i] <= sert_pkg::StCommit; tk_q[i] <= '0;
      end
      first_q <= '0; next_q <= '0; cmt_q <= '0; stop_q <= '1;
      flag_q <= '0; walk_q <= '0; k_q <= '0; dist_q <= '0;
      rvld_q <= 1'b0; rsp_q <= '0;
    end else begin
      state_q <= state_d;
      st_q <= st_d; tk_q <= tk_d;
      first_q <= first_d; next_q <= next_d; cmt_q <= cmt_d; stop_q <= stop_d;
      flag_q <= flag_d; walk_q <= walk_d; k_q <= k_d; dist_q <= dist_d;
      rvld_q <= rvld_d; rsp_q <= rsp_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/speculative_epoch_ring_tracker.sv
// Top level of the speculative epoch ring tracker.
//
// Usage: requests enter through a queue-style port (push_i / full_o); a
// transaction is taken on a rising edge with push_i high and full_o low.
// Each request yields exactly one response, presented while empty_o is low
// and retired on an edge with pop_i high. The ring has sert_pkg::Depth slots.
// A two-entry intake queue decouples intake from the executor, which works
// one request at a time. A simple request is held in the intake queue and its
// response is registered in the executor; one request per cycle is sustained
// for simple requests when each response is popped at once. Rollback walks
// one slot a cycle over at most Depth slots; commit done advances the first
// cursor one slot a cycle, up to Depth slots; no new request is taken until
// the walk ends and its response is registered.
// Reset clears all slots to commit, cursors to zero, the stop bound to all
// ones and the flag bits; the block is usable the cycle after reset.
// When the receiver stalls, hold the response; the executor halts and the
// intake queue fills, then full_o rises.
`default_nettype none
module speculative_epoch_ring_tracker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire sert_pkg::req_t req_i,
  output logic                empty_o,
  input  wire logic           pop_i,
  output sert_pkg::rsp_t      rsp_o
);
  sert_pkg::req_t q_req;
  logic q_vld, q_take, r_vld;

  sert_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i,
    .vld_o(q_vld), .take_i(q_take), .req_o(q_req)
  );

  sert_back u_back (
    .clk_i, .rst_ni, .vld_i(q_vld), .take_o(q_take), .req_i(q_req),
    .rvld_o(r_vld), .rtake_i(pop_i), .rsp_o
  );

  assign empty_o = !r_vld;
endmodule
`default_nettype wire

// File: tb/tb_speculative_epoch_ring_tracker.sv
// Self-checking testbench for the speculative epoch ring tracker.
`default_nettype none
module tb_speculative_epoch_ring_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth    = sert_pkg::Depth;
  localparam int unsigned SlotBits = sert_pkg::SlotBits;
  localparam int unsigned NumItems = 1600;
  localparam logic [3:0]  ReqBadLow  = 4'd10;
  localparam logic [3:0]  ReqBadHigh = 4'd15;

  // Predicts each response from its own copy of the ring and keeps the
  // responses still owed by the block, oldest first.
  class ring_expectations;
    logic [sert_pkg::StBits-1:0] slot_st[Depth];
    logic [15:0]       slot_tag[Depth];
    logic [31:0]       first_ep, next_ep, commit_ep, stop_ep;
    logic [Depth-1:0]  flags;
    sert_pkg::rsp_t    owed[$];
    int unsigned       mismatches, checked;
    int unsigned       code_seen[4];

    function new();
      foreach (slot_st[i]) begin
        slot_st[i]  = sert_pkg::StCommit;
        slot_tag[i] = '0;
      end
      first_ep = '0; next_ep = '0; commit_ep = '0; stop_ep = '1; flags = '0;
      mismatches = 0; checked = 0;
      foreach (code_seen[i]) code_seen[i] = 0;
    endfunction

    function logic [SlotBits-1:0] slot_of(logic [31:0] e);
      return e[SlotBits-1:0];
    endfunction

    // Serial comparison: sign of a-b read modulo 2^32.
    function int serial_cmp(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      if (d == 0) return 0;
      return d[31] ? -1 : 1;
    endfunction

    function bit stop_armed();
      return serial_cmp(stop_ep, first_ep) >= 0;
    endfunction

    function void note_request(sert_pkg::req_t r);
      sert_pkg::rsp_t      p;
      logic [SlotBits-1:0] s, ns, cs;
      logic [2:0]          st;
      logic [31:0]         e, span_left, nstop;
      int                  k;
      p = '0;
      s = slot_of(r.epoch_in);
      case (r.req_type)
        sert_pkg::ReqNext: begin
          ns = slot_of(next_ep);
          st = slot_st[ns];
          if (next_ep != first_ep && ns == slot_of(first_ep))
            p.result_code = sert_pkg::CodeBusy;
          else if (st == sert_pkg::StPend) p.result_code = sert_pkg::CodeBusy;
          else if (stop_armed() && serial_cmp(next_ep, stop_ep) >= 0)
            p.result_code = (stop_ep == first_ep) ? sert_pkg::CodeStopped
                                                  : sert_pkg::CodeBusy;
          else if (st != sert_pkg::StCommit && st != sert_pkg::StRb)
            p.result_code = sert_pkg::CodeIllegal;
          else begin
            p.epoch_out  = next_ep;
            p.status_out = st;
            slot_st[ns]  = sert_pkg::StExec;
            next_ep      = next_ep + 1;
          end
        end
        sert_pkg::ReqSetDone: begin
          st = slot_st[s];
          p.status_out = st;
          if (st == sert_pkg::StExec) slot_st[s] = sert_pkg::StDone;
          else if (st == sert_pkg::StPend) slot_st[s] = sert_pkg::StRb;
          else p.result_code = sert_pkg::CodeIllegal;
        end
        sert_pkg::ReqRollback: begin
          e = r.epoch_in;
          if (stop_armed() && serial_cmp(stop_ep, e) > 0) stop_ep = first_ep - 1;
          span_left = (serial_cmp(e, next_ep) < 0) ? next_ep - e : '0;
          // walk at most one lap; beyond that every slot is already marked
          for (k = 0; k < Depth && k < span_left; k++) begin
            if (slot_st[slot_of(e)] == sert_pkg::StExec) begin
              slot_st[slot_of(e)] = sert_pkg::StPend;
              flags[slot_of(e)] = 1'b1;
            end else if (slot_st[slot_of(e)] == sert_pkg::StDone) begin
              slot_st[slot_of(e)] = sert_pkg::StRb;
              flags[slot_of(e)] = 1'b1;
            end
            e = e + 1;
          end
          if (serial_cmp(next_ep, r.epoch_in) > 0) next_ep = r.epoch_in;
        end
        sert_pkg::ReqRbDone: flags[s] = 1'b0;
        sert_pkg::ReqGetCmt: begin
          cs = slot_of(commit_ep);
          if (commit_ep == next_ep) p.result_code = sert_pkg::CodeStopped;
          else if (slot_st[cs] != sert_pkg::StDone) p.result_code = sert_pkg::CodeStopped;
          else if (stop_armed() && stop_ep == commit_ep)
            p.result_code = sert_pkg::CodeStopped;
          else begin
            p.epoch_out  = commit_ep;
            p.status_out = sert_pkg::StDone;
            p.task_out   = slot_tag[cs];
            slot_tag[cs] = '0;
            commit_ep    = commit_ep + 1;
          end
        end
        sert_pkg::ReqCmtDone: begin
          st = slot_st[s];
          p.status_out = st;
          if (st != sert_pkg::StDone) p.result_code = sert_pkg::CodeIllegal;
          else begin
            slot_st[s] = sert_pkg::StCommit;
            // advance first over committed slots; a full lap jumps to commit
            for (k = 0; k < Depth; k++) begin
              if (first_ep == commit_ep) break;
              if (slot_st[slot_of(first_ep)] != sert_pkg::StCommit) break;
              first_ep = first_ep + 1;
            end
            if (k == Depth) first_ep = commit_ep;
            if (!stop_armed()) stop_ep = first_ep - 1;
          end
        end
        sert_pkg::ReqStop: begin
          nstop = r.epoch_in + 1;
          if (!(stop_armed() && serial_cmp(stop_ep, nstop) < 0)) stop_ep = nstop;
        end
        sert_pkg::ReqStatus:  p.status_out = slot_st[s];
        sert_pkg::ReqSetTask: slot_tag[s] = r.task_in;
        sert_pkg::ReqGetTask: p.task_out = slot_tag[s];
        default:    p.result_code = sert_pkg::CodeIllegal;
      endcase
      p.head_epoch     = first_ep;
      p.tail_epoch     = next_ep;
      p.rollback_flags = flags;
      owed.push_back(p);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got,
                              ref bit bad);
      if (want !== got) begin
        bad = 1'b1;
        if (mismatches < 10)
          $display("  mismatch %0s at response %0d: expected %h, got %h",
                   name, checked, want, got);
      end
    endfunction

    function void check_response(sert_pkg::rsp_t got);
      sert_pkg::rsp_t want;
      bit   bad;
      bad = 1'b0;
      if (owed.size() == 0) begin
        if (mismatches < 10) $display("  unexpected response %p", got);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      field_check("result_code", 32'(want.result_code), 32'(got.result_code), bad);
      field_check("epoch_out", want.epoch_out, got.epoch_out, bad);
      field_check("status_out", 32'(want.status_out), 32'(got.status_out), bad);
      field_check("task_out", 32'(want.task_out), 32'(got.task_out), bad);
      field_check("head_epoch", want.head_epoch, got.head_epoch, bad);
      field_check("tail_epoch", want.tail_epoch, got.tail_epoch, bad);
      field_check("rollback_flags", 32'(want.rollback_flags), 32'(got.rollback_flags),
                  bad);
      if (bad) mismatches++;
      code_seen[got.result_code]++;
      checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  sert_pkg::req_t req_i = '0;
  logic full_o, empty_o;
  sert_pkg::rsp_t rsp_o;

  ring_expectations ring = new();
  bit          no_idle = 1'b0;    // long stretch with both sides always busy
  bit          hold_start = 1'b0; // ask the receiver for one long hold-off
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;     // receiver hold-off, counted down below
  int unsigned req_count[16];

  speculative_epoch_ring_tracker dut (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i, .empty_o, .pop_i, .rsp_o
  );

  always #6 clk_i = ~clk_i;

  // Watch both handshakes at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) begin
      ring.note_request(req_i);
      req_count[req_i.req_type]++;
    end
    if (rst_ni && pop_i && !empty_o) ring.check_response(rsp_o);
  end

  // Receiver: pop at random, or hold off for a long stretch once.
  always @(negedge clk_i) begin
    if (hold_start && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 200;
      pop_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // Offer one transaction from a falling edge and hold it until taken.
  task automatic send_request(sert_pkg::req_t r);
    while (!no_idle && $urandom_range(99) < 31) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i <= 1'b1;
    req_i  <= r;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  function automatic sert_pkg::req_t mk(logic [3:0] op, logic [31:0] ep, logic [15:0] tg);
    sert_pkg::req_t r;
    r.req_type = op;
    r.epoch_in = ep;
    r.task_in  = tg;
    return r;
  endfunction

  // Mostly well-formed traffic aimed near the cursors; some noise.
  function automatic sert_pkg::req_t random_request();
    int unsigned pick;
    logic [31:0] span, near;
    pick = $urandom_range(99);
    span = ring.next_ep - ring.first_ep;
    near = ring.first_ep + $urandom_range((span > 20) ? 20 : span);
    if (pick < 25) return mk(sert_pkg::ReqNext, $urandom, 16'($urandom));
    if (pick < 33) return mk(sert_pkg::ReqSetTask, near, 16'($urandom));
    if (pick < 53) return mk(sert_pkg::ReqSetDone, near, 16'($urandom));
    if (pick < 65) return mk(sert_pkg::ReqGetCmt, $urandom, 16'($urandom));
    if (pick < 80)
      return mk(sert_pkg::ReqCmtDone, ring.commit_ep - $urandom_range(3), 16'($urandom));
    if (pick < 84) return mk(sert_pkg::ReqStatus, near, 16'($urandom));
    if (pick < 88) return mk(sert_pkg::ReqGetTask, near, 16'($urandom));
    if (pick < 92) return mk(sert_pkg::ReqRollback, near, 16'($urandom));
    if (pick < 95) return mk(sert_pkg::ReqRbDone, near, 16'($urandom));
    if (pick < 97)
      return mk(sert_pkg::ReqStop,
                ($urandom_range(1)) ? ring.next_ep + $urandom_range(8) : $urandom,
                16'($urandom));
    return mk(4'($urandom_range(15)), $urandom, 16'($urandom));
  endfunction

  initial begin
    int i;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every request, unknown codes, field extremes.
    send_request(mk(sert_pkg::ReqStatus, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(mk(sert_pkg::ReqGetCmt, '0, '0));          // nothing to commit
    send_request(mk(sert_pkg::ReqCmtDone, '0, '0));         // slot not done
    send_request(mk(sert_pkg::ReqSetDone, '0, '0));         // slot not executing
    for (i = 0; i < 17; i++) send_request(mk(sert_pkg::ReqNext, '0, '0)); // fills ring
    send_request(mk(sert_pkg::ReqNext, '0, '0));            // still full: busy
    send_request(mk(sert_pkg::ReqSetTask, 32'd0, 16'hFFFF));
    send_request(mk(sert_pkg::ReqGetTask, 32'd16, '0));
    send_request(mk(sert_pkg::ReqSetDone, 32'd0, '0));
    send_request(mk(sert_pkg::ReqSetDone, 32'd1, '0));
    send_request(mk(sert_pkg::ReqRollback, 32'd2, '0));     // marks executing slots pending
    send_request(mk(sert_pkg::ReqNext, '0, '0));            // lands on pending slot
    send_request(mk(sert_pkg::ReqGetCmt, '0, '0));
    send_request(mk(sert_pkg::ReqCmtDone, 32'd0, '0));
    send_request(mk(sert_pkg::ReqRbDone, 32'd3, '0));
    send_request(mk(sert_pkg::ReqStop, 32'hFFFF_FFFF, '0)); // bound wraps to zero
    send_request(mk(sert_pkg::ReqStop, 32'd0, '0));
    send_request(mk(sert_pkg::ReqRollback, 32'hFFFF_FFF0, '0)); // far behind: long walk
    send_request(mk(ReqBadLow, 32'hAAAA_5555, 16'h5A5A));
    send_request(mk(ReqBadHigh, 32'h5555_AAAA, 16'hA5A5));

    for (i = 0; i < NumItems; i++) begin
      if (i == 300) hold_start = 1'b1;            // fill the block, stall intake
      if (i == 700) begin                         // drain completely
        push_i <= 1'b0;
        while (ring.owed.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      if (i == 900) no_idle = 1'b1;
      if (i == 1150) no_idle = 1'b0;
      send_request(random_request());
    end
    push_i <= 1'b0;

    while (ring.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d responses: %0d ok, %0d busy, %0d stopped, %0d illegal.",
             ring.checked, ring.code_seen[0], ring.code_seen[1], ring.code_seen[2],
             ring.code_seen[3]);
    $display("Requests: %0d next, %0d rollback, %0d commit done; %0d mismatches.",
             req_count[sert_pkg::ReqNext], req_count[sert_pkg::ReqRollback],
             req_count[sert_pkg::ReqCmtDone], ring.mismatches);
    if (ring.mismatches == 0 && ring.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d responses outstanding.", ring.owed.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/sert_pkg.sv
hdl/sert_front.sv
hdl/sert_back.sv
hdl/speculative_epoch_ring_tracker.sv
tb/tb_speculative_epoch_ring_tracker.sv
